### rtl/assert_macros.svh
// assertion helpers for the checker file anbs_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/anbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package anbs_pkg;

  localparam int POS_W = 32;
  localparam int TZ_W = 32;
  localparam int OUT_W = 32;
  localparam int EXT_W = (POS_W + 2 > TZ_W + 1) ? POS_W + 2 : TZ_W + 1;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE = 8'h01;
  localparam logic [2:0] LEN_SHORT = 3'd3;
  localparam logic [2:0] LEN_LONG = 3'd4;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [EXT_W-1:0] ext_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } anbs_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] unit_offset;
    logic [2:0]       prefix_length;
    logic [1:0]       ref_priority;
    logic [4:0]       unit_kind;
    logic [OUT_W-1:0] body_size;
    logic [OUT_W-1:0] whole_size;
  } anbs_out_t;

  // saturate a wide value into an output field
  function automatic logic [OUT_W-1:0] clip_out(input ext_t v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'({OUT_W{1'b1}})) begin
      clip_out = {OUT_W{1'b1}};
    end else begin
      clip_out = w[OUT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_req_i  (anbs_in_t)
// out     | out_valid_o| out_stall_i | out_req_o (anbs_out_t)
//
// one byte per cycle while in_stall_o is low; scan state updates in the cycle a byte is taken
// a result shows on the output register in the cycle after its byte is taken
// in_stall_o is high only while a result is held and out_stall_i is high
// reset clears the scan state and the output valid; positions restart
// after every final byte

module annexb_nal_unit_splitter
  import anbs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire anbs_in_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output anbs_out_t      out_req_o
);

  pos_t            pos_q, pos_d;
  logic [1:0]      zrun_q, zrun_d;
  logic            open_q, open_d;
  pos_t            off_q, off_d;
  logic [2:0]      len_q, len_d;
  ext_t            end_q, end_d;
  logic [7:0]      hdr_q, hdr_d;
  logic [TZ_W-1:0] tz_q, tz_d;
  logic            pend_q, pend_d;
  logic            out_valid_q;
  anbs_out_t       out_q, res_d;

  logic            accept;
  logic [7:0]      b;
  logic            last;
  logic            sc, four, emit_sc, emit_fin, emit;
  pos_t            this_off;
  logic [2:0]      this_len;
  ext_t            size, rem, unit_sc, unit_fin, unit_sel;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept = in_valid_i & ~in_stall_o;
  assign b = in_req_i.byte_value;
  assign last = in_req_i.final_byte;
  assign size = ext_t'(pos_q) + ext_t'(1);

  always_comb begin
    hdr_d = pend_q ? b : hdr_q;
    pend_d = 1'b0;
    open_d = open_q;
    off_d = off_q;
    len_d = len_q;
    end_d = end_q;

    // start code detection
    sc = (b == BYTE_ONE) && (zrun_q >= 2'd2) && (pos_q >= pos_t'(2));
    four = (zrun_q == 2'd3) && (pos_q >= pos_t'(3));
    this_off = four ? pos_q - pos_t'(3) : pos_q - pos_t'(2);
    this_len = four ? LEN_LONG : LEN_SHORT;
    unit_sc = ext_t'(this_off) - end_q;
    emit_sc = sc && open_q && (ext_t'(this_off) > end_q);

    if (sc) begin
      open_d = 1'b1;
      off_d = this_off;
      len_d = this_len;
      end_d = size;
      pend_d = 1'b1;
    end

    if (b == BYTE_ZERO) begin
      zrun_d = (zrun_q == 2'd3) ? zrun_q : zrun_q + 2'd1;
      tz_d = (tz_q == {TZ_W{1'b1}}) ? tz_q : tz_q + TZ_W'(1);
    end else begin
      zrun_d = 2'd0;
      tz_d = '0;
    end

    // end of buffer: trim trailing zeros from the open unit
    rem = size - end_q;
    unit_fin = rem - ext_t'(tz_d);
    emit_fin = last && !sc && open_q && (end_q < size) && (rem > ext_t'(tz_d));

    emit = emit_sc || emit_fin;
    unit_sel = emit_sc ? unit_sc : unit_fin;

    res_d.unit_offset = clip_out(ext_t'(off_q));
    res_d.prefix_length = len_q;
    res_d.ref_priority = hdr_d[6:5];
    res_d.unit_kind = hdr_d[4:0];
    res_d.body_size = clip_out(unit_sel - ext_t'(1));
    res_d.whole_size = clip_out(unit_sel + ext_t'(len_q));

    if (last) begin
      pos_d = '0;
      zrun_d = 2'd0;
      open_d = 1'b0;
      off_d = '0;
      len_d = 3'd0;
      end_d = '0;
      hdr_d = 8'd0;
      tz_d = '0;
      pend_d = 1'b0;
    end else if (pos_q != {POS_W{1'b1}}) begin
      pos_d = pos_q + pos_t'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      zrun_q <= 2'd0;
      open_q <= 1'b0;
      off_q <= '0;
      len_q <= 3'd0;
      end_q <= '0;
      hdr_q <= 8'd0;
      tz_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
        zrun_q <= zrun_d;
        open_q <= open_d;
        off_q <= off_d;
        len_q <= len_d;
        end_q <= end_d;
        hdr_q <= hdr_d;
        tz_q <= tz_d;
        pend_q <= pend_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o = out_q;

endmodule

`default_nettype wire

### rtl/anbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module anbs_checker
  import anbs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire anbs_out_t out_req_o
);

  logic [OUT_W+1:0] whole_sum;
  logic             held;
  logic             len_ok;
  logic             size_ok;

  assign whole_sum = (OUT_W+2)'(out_req_o.body_size) + (OUT_W+2)'(1)
                   + (OUT_W+2)'(out_req_o.prefix_length);
  assign held = out_valid_o && out_stall_i;
  assign len_ok = (out_req_o.prefix_length == LEN_SHORT)
               || (out_req_o.prefix_length == LEN_LONG);
  assign size_ok = (out_req_o.whole_size == {OUT_W{1'b1}})
                || ((OUT_W+2)'(out_req_o.whole_size) == whole_sum);

  // held request stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(out_req_o))
  // input backs up only behind a held result
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, held)
  // a new result needs a byte taken the cycle before
  `ASSERT_IMPLY(a_out_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o))
  // start code length and size bookkeeping agree
  `ASSERT_IMPLY(a_sizes, clk_i, rst_ni, out_valid_o, len_ok && size_ok)

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire
